/* rtl/core/ftks_pkg.sv */
package ftks_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned TOP_IDX_W = 16;
    localparam int unsigned K_W       = 7;

    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic               batch_end;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   top_value_bits;
        logic [TOP_IDX_W-1:0] top_index;
        logic                 run_last;
    } out_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // signed rank key: negative floats are mirrored so ordering is total
    function automatic logic [VALUE_W-1:0] make_key(input logic [VALUE_W-1:0] bits);
        logic [VALUE_W-1:0] res;
        if (bits[VALUE_W-1]) begin
            res = 32'h7FFF_FFFF - bits;
        end else begin
            res = bits;
        end
        return res;
    endfunction

endpackage

/* rtl/core/ftks_cell.sv */
module ftks_cell #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ftks_pkg::cell_ctrl_t   ctrl,
    input  logic [31:0]            new_key,
    input  logic [31:0]            new_bits,
    input  logic [INDEX_BITS-1:0]  new_index,
    input  logic                   prev_keep,
    input  logic                   prev_valid,
    input  logic [31:0]            prev_key,
    input  logic [31:0]            prev_bits,
    input  logic [INDEX_BITS-1:0]  prev_index,
    input  logic                   next_valid,
    input  logic [31:0]            next_key,
    input  logic [31:0]            next_bits,
    input  logic [INDEX_BITS-1:0]  next_index,
    output logic                   keep,
    output logic                   valid,
    output logic [31:0]            key,
    output logic [31:0]            bits,
    output logic [INDEX_BITS-1:0]  index
);

    logic                  valid_reg, valid_next;
    logic [31:0]           key_reg, key_next;
    logic [31:0]           bits_reg, bits_next;
    logic [INDEX_BITS-1:0] index_reg, index_next;

    // held entry stays put when it ranks at or above the incoming request
    assign keep = valid_reg && ($signed(key_reg) >= $signed(new_key));

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        bits_next  = bits_reg;
        index_next = index_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.insert) begin
            if (!keep) begin
                if (prev_keep) begin
                    valid_next = 1'b1;
                    key_next   = new_key;
                    bits_next  = new_bits;
                    index_next = new_index;
                end else begin
                    valid_next = prev_valid;
                    key_next   = prev_key;
                    bits_next  = prev_bits;
                    index_next = prev_index;
                end
            end
        end else if (ctrl.shift) begin
            valid_next = next_valid;
            key_next   = next_key;
            bits_next  = next_bits;
            index_next = next_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        bits_reg  <= bits_next;
        index_reg <= index_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign bits  = bits_reg;
    assign index = index_reg;

endmodule

/* rtl/core/float_top_k_select_core.sv */
// channel   | ports                   | payload
// ----------+-------------------------+-------------------------------------
// request   | s_valid s_ready s_data  | value_bits, batch_end
// result    | m_valid m_ready m_data  | top_value_bits, top_index, run_last
// config    | cfg_wr_en cfg_wr_data   | k_count
//
// a request without batch_end: every cell of the insertion chain
// compares against it in parallel and the chain shifts in the same edge
// a request with batch_end is inserted the same way, then min(k, count) results
// drain, the chain shifting toward cell 0 once per accepted result
// s_ready is low while results drain; m_ready low simply holds the chain
// synchronous reset clears the cell valid bits and counters, k_count returns to 1
module float_top_k_select_core #(
    parameter int unsigned MAX_K      = 64,
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ftks_pkg::in_t         s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ftks_pkg::out_t        m_data,
    input  logic                  cfg_wr_en,
    input  logic [ftks_pkg::K_W-1:0] cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_K + 1);
    localparam logic [CNT_W-1:0] MAX_K_CNT = CNT_W'(MAX_K);

    ftks_pkg::state_t state_reg, state_next;
    logic [ftks_pkg::K_W-1:0] k_reg;
    logic [INDEX_BITS-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic [CNT_W-1:0]         fill_inc;
    logic [CNT_W-1:0]         keff;
    logic [31:0]              k_ext;
    logic [31:0]              idx_ext;
    logic [31:0]              new_key;
    logic                     s_fire, m_fire;
    ftks_pkg::cell_ctrl_t     ctrl;

    logic                  c_keep  [MAX_K];
    logic                  c_valid [MAX_K];
    logic [31:0]           c_key   [MAX_K];
    logic [31:0]           c_bits  [MAX_K];
    logic [INDEX_BITS-1:0] c_index [MAX_K];

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign new_key = ftks_pkg::make_key(s_data.value_bits);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= ftks_pkg::K_W'(1);
        end else if (cfg_wr_en) begin
            k_reg <= cfg_wr_data;
        end
    end

    // effective k: zero acts as one, saturate at chain length
    always_comb begin
        k_ext = 32'(k_reg);
        if (k_ext == 32'd0) begin
            keff = CNT_W'(1);
        end else if (k_ext > 32'(MAX_K)) begin
            keff = MAX_K_CNT;
        end else begin
            keff = CNT_W'(k_ext);
        end
    end

    assign fill_inc = (fill_reg == MAX_K_CNT) ? fill_reg : fill_reg + CNT_W'(1);

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        ctrl        = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            ftks_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    ctrl.insert = 1'b1;
                    if (s_data.batch_end) begin
                        pos_next    = '0;
                        fill_next   = '0;
                        remain_next = (keff < fill_inc) ? keff : fill_inc;
                        state_next  = ftks_pkg::ST_DRAIN;
                    end else begin
                        fill_next = fill_inc;
                        if (pos_reg != '1) begin
                            pos_next = pos_reg + INDEX_BITS'(1);
                        end
                    end
                end
            end
            ftks_pkg::ST_DRAIN: begin
                m_valid = 1'b1;
                if (m_fire) begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        ctrl.clear = 1'b1;
                        state_next = ftks_pkg::ST_IDLE;
                    end else begin
                        ctrl.shift = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ftks_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ftks_pkg::ST_IDLE;
            pos_reg    <= '0;
            fill_reg   <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++) begin : g_cell
            logic                  p_keep, p_valid, n_valid;
            logic [31:0]           p_key, p_bits, n_key, n_bits;
            logic [INDEX_BITS-1:0] p_index, n_index;

            if (gi == 0) begin : g_head
                assign p_keep  = 1'b1;
                assign p_valid = 1'b0;
                assign p_key   = '0;
                assign p_bits  = '0;
                assign p_index = '0;
            end else begin : g_body
                assign p_keep  = c_keep[gi-1];
                assign p_valid = c_valid[gi-1];
                assign p_key   = c_key[gi-1];
                assign p_bits  = c_bits[gi-1];
                assign p_index = c_index[gi-1];
            end

            if (gi == MAX_K - 1) begin : g_tail
                assign n_valid = 1'b0;
                assign n_key   = '0;
                assign n_bits  = '0;
                assign n_index = '0;
            end else begin : g_link
                assign n_valid = c_valid[gi+1];
                assign n_key   = c_key[gi+1];
                assign n_bits  = c_bits[gi+1];
                assign n_index = c_index[gi+1];
            end

            ftks_cell #(
                .INDEX_BITS (INDEX_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_key    (new_key),
                .new_bits   (s_data.value_bits),
                .new_index  (pos_reg),
                .prev_keep  (p_keep),
                .prev_valid (p_valid),
                .prev_key   (p_key),
                .prev_bits  (p_bits),
                .prev_index (p_index),
                .next_valid (n_valid),
                .next_key   (n_key),
                .next_bits  (n_bits),
                .next_index (n_index),
                .keep       (c_keep[gi]),
                .valid      (c_valid[gi]),
                .key        (c_key[gi]),
                .bits       (c_bits[gi]),
                .index      (c_index[gi])
            );
        end
    endgenerate

    assign idx_ext                = 32'(c_index[0]);
    assign m_data.top_value_bits  = c_bits[0];
    assign m_data.top_index       = idx_ext[ftks_pkg::TOP_IDX_W-1:0];
    assign m_data.run_last        = (remain_reg == CNT_W'(1));

    a_drain_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> c_valid[0])
        else $error("result offered from an empty head cell");

    a_drain_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ftks_pkg::ST_DRAIN) |-> (remain_reg != '0))
        else $error("drain state with no results left");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_data.run_last) |=> (state_reg == ftks_pkg::ST_IDLE && !c_valid[0]
            && fill_reg == '0 && pos_reg == '0))
        else $error("chain not cleared after final result");

    a_fill_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_data.batch_end && fill_reg != MAX_K_CNT)
            |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("fill count did not follow an insert");

endmodule
